FILE: src/binary_image_edge_extractor_core_assert.svh
// Assertion macros for the binary image edge extractor, clocked on aclk and disabled in reset.
`ifndef BINARY_IMAGE_EDGE_EXTRACTOR_CORE_ASSERT_SVH
`define BINARY_IMAGE_EDGE_EXTRACTOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BIEE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BIEE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/biee_pkg.sv
// Package with constants and types of the binary image edge extractor.
package biee_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int CFG_W      = 13;
    localparam int ROW_W      = 13;
    localparam int OUT_POS_W  = 12;
    localparam int ALPHA_W    = 8;
    localparam int EDGE_W     = 8;

    localparam logic [EDGE_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [EDGE_W-1:0] EDGE_OFF = 8'd0;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd32;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd32;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic                 bit_set;
        logic [COL_W-1:0]     col;
        logic [COL_W-1:0]     ocol;
        logic [OUT_POS_W-1:0] orow;
        logic                 have;
        logic                 last;
    } stage_t;

endpackage

FILE: src/binary_image_edge_extractor_core.sv
// Top level of the binary image edge extractor: 8-connected inner boundary of an alpha stream.
//
//  Channel   Ports                          Contents
//  input     s_tvalid s_tready s_tdata      tdata: alpha; tuser: op (1 = flush)
//  result    m_tvalid m_tready m_tdata      tdata: edge_value, col, row; tlast: frame_last
//  config    cfg_wr_en cfg_wr_index cfg_wr_data   0 = image_width, 1 = image_height
//
// One transaction is accepted per cycle while s_tready is high; its result passes through
// the working stage into the output register, and it belongs to the pixel one row plus
// one pixel earlier. After reset the line store is cleared one column per cycle over all
// LINE_DEPTH (4096) columns, with s_tready low. The line store read is registered at accept
// time, with a bypass from the write of the transaction ahead. A stalled output holds the
// working stage, and s_tready then falls.
module binary_image_edge_extractor_core
    import biee_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_index,
    input  logic [CFG_W-1:0]           cfg_wr_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ALPHA_W-1:0]         s_tdata,  // [7:0] alpha
    input  logic                       s_tuser,  // [0] op
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,  // [7:0] edge_value, [19:8] col, [31:20] row
    output logic                       m_tlast
);

`include "binary_image_edge_extractor_core_assert.svh"

    logic [CFG_W-1:0]     width_reg;
    logic [CFG_W-1:0]     height_reg;
    logic [CFG_W-1:0]     w_eff;
    logic [CFG_W-1:0]     h_eff;

    logic                 clr_active_reg;
    logic [COL_W-1:0]     clr_addr_reg;

    logic [COL_W-1:0]     in_col_reg;
    logic [ROW_W-1:0]     in_row_reg;
    logic [COL_W-1:0]     in_col_next;
    logic [ROW_W-1:0]     in_row_next;

    logic                 st_valid_reg;
    stage_t               st_reg;
    stage_t               st_next;
    logic [1:0]           line_rd_reg;

    logic [2:0]           win_left_reg;
    logic [2:0]           win_centre_reg;

    logic                 out_valid_reg;
    logic [31:0]          out_data_reg;
    logic                 out_last_reg;

    logic [1:0]           line_mem [LINE_DEPTH];
    logic                 mem_we;
    logic [COL_W-1:0]     mem_waddr;
    logic [1:0]           mem_wdata;

    logic                 accept;
    logic                 advance;

    logic [COL_W-1:0]     c_cur;
    logic [ROW_W-1:0]     r_cur;
    logic                 col_zero;
    logic [ROW_W-1:0]     orow_full;
    logic [CFG_W-1:0]     ocol_full;
    logic                 have_s0;
    logic                 last_s0;
    logic [CFG_W:0]       col_inc;

    logic [2:0]           colbits;
    logic                 has_left;
    logic                 has_right;
    logic                 has_top;
    logic                 has_bottom;
    logic                 is_edge;

    // Effective frame size.
    always_comb begin
        if (width_reg == '0) begin
            w_eff = CFG_W'(1);
        end else if ((CFG_W+1)'(width_reg) > (CFG_W+1)'(MAX_WIDTH)) begin
            w_eff = CFG_W'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == '0) begin
            h_eff = CFG_W'(1);
        end else if ((CFG_W+1)'(height_reg) > (CFG_W+1)'(MAX_HEIGHT)) begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wr_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Handshake.
    assign advance  = st_valid_reg && (!st_reg.have || !out_valid_reg || m_tready);
    assign s_tready = !clr_active_reg && (!st_valid_reg || advance);
    assign accept   = s_tvalid && s_tready;

    // Position of the incoming transaction and the result it produces.
    always_comb begin
        c_cur = in_col_reg;
        r_cur = in_row_reg;
        if (CFG_W'(in_col_reg) >= w_eff) begin
            c_cur = '0;
        end
        if ((ROW_W+1)'(in_row_reg) > (ROW_W+1)'(h_eff) + (ROW_W+1)'(1)) begin
            r_cur = '0;
            c_cur = '0;
        end
        col_zero = (c_cur == '0);
        if (col_zero) begin
            have_s0   = (r_cur >= ROW_W'(2));
            orow_full = r_cur - ROW_W'(2);
            ocol_full = w_eff - CFG_W'(1);
        end else begin
            have_s0   = (r_cur >= ROW_W'(1));
            orow_full = r_cur - ROW_W'(1);
            ocol_full = CFG_W'(c_cur) - CFG_W'(1);
        end
        if (CFG_W'(orow_full) >= h_eff) begin
            have_s0 = 1'b0;
        end
        last_s0 = have_s0 && (CFG_W'(orow_full) == h_eff - CFG_W'(1))
                  && (ocol_full == w_eff - CFG_W'(1));

        col_inc     = (CFG_W+1)'(c_cur) + (CFG_W+1)'(1);
        in_col_next = c_cur + COL_W'(1);
        in_row_next = r_cur;
        if (col_inc >= (CFG_W+1)'(w_eff)) begin
            in_col_next = '0;
            in_row_next = r_cur + ROW_W'(1);
        end
        if (last_s0) begin
            in_col_next = '0;
            in_row_next = '0;
        end

        st_next.bit_set = (s_tuser == OP_PIXEL) && (s_tdata != '0);
        st_next.col     = c_cur;
        st_next.ocol    = COL_W'(ocol_full);
        st_next.orow    = OUT_POS_W'(orow_full);
        st_next.have    = have_s0;
        st_next.last    = last_s0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            st_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                in_col_reg   <= in_col_next;
                in_row_reg   <= in_row_next;
                st_valid_reg <= 1'b1;
            end else if (advance) begin
                st_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_reg <= st_next;
        end
    end

    // Line store clearing after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + COL_W'(1);
            if (clr_addr_reg == COL_W'(LINE_DEPTH - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Line store: bit 0 holds the row above, bit 1 the current row.
    always_comb begin
        if (clr_active_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = 2'b00;
        end else begin
            mem_we    = advance;
            mem_waddr = st_reg.col;
            mem_wdata = {st_reg.bit_set, line_rd_reg[1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            if (mem_we && (mem_waddr == c_cur)) begin
                line_rd_reg <= mem_wdata;
            end else begin
                line_rd_reg <= line_mem[c_cur];
            end
        end
    end

    // Window and edge decision.
    always_comb begin
        colbits    = {st_reg.bit_set, line_rd_reg[1], line_rd_reg[0]};
        has_left   = (st_reg.ocol != '0);
        has_right  = ((CFG_W+1)'(st_reg.ocol) + (CFG_W+1)'(1)) < (CFG_W+1)'(w_eff);
        has_top    = (st_reg.orow != '0);
        has_bottom = ((CFG_W+1)'(st_reg.orow) + (CFG_W+1)'(1)) < (CFG_W+1)'(h_eff);
        is_edge = win_centre_reg[1] && (
            (has_left  && ((has_top && !win_left_reg[0]) || !win_left_reg[1]
                           || (has_bottom && !win_left_reg[2])))
            || (has_top    && !win_centre_reg[0])
            || (has_bottom && !win_centre_reg[2])
            || (has_right && ((has_top && !colbits[0]) || !colbits[1]
                              || (has_bottom && !colbits[2]))));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_left_reg   <= '0;
            win_centre_reg <= '0;
        end else if (advance) begin
            win_left_reg   <= win_centre_reg;
            win_centre_reg <= colbits;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && st_reg.have) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && st_reg.have) begin
            out_data_reg <= {st_reg.orow, OUT_POS_W'(st_reg.ocol), is_edge ? EDGE_ON : EDGE_OFF};
            out_last_reg <= st_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `BIEE_ASSERT_NOW(a_no_accept_in_clear, clr_active_reg, !s_tready,
        "transaction accepted during line store clearing")
    `BIEE_ASSERT_NEXT(a_stage_holds, st_valid_reg && st_reg.have && out_valid_reg && !m_tready,
        st_valid_reg && $stable(st_reg), "working stage lost while output stalled")
    `BIEE_ASSERT_NEXT(a_frame_restart, accept && last_s0,
        (in_col_reg == '0) && (in_row_reg == '0), "position not reset after frame end")
    `BIEE_ASSERT_NOW(a_clear_length, $fell(clr_active_reg),
        $past(clr_addr_reg) == COL_W'(LINE_DEPTH - 1), "line store clearing ended early")

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the streaming 8-connected inner-boundary extractor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import biee_pkg::*;

    localparam int QUIET_LIMIT   = 25000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [EDGE_W-1:0]    edge_value;
        logic [OUT_POS_W-1:0] col;
        logic [OUT_POS_W-1:0] row;
        logic                 frame_last;
    } edge_result_t;

    logic                aclk         = 1'b0;
    logic                aresetn      = 1'b0;
    logic                cfg_wr_en    = 1'b0;
    logic                cfg_wr_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]    cfg_wr_data  = '0;
    logic                s_tvalid     = 1'b0;
    logic                s_tready;
    logic [ALPHA_W-1:0]  s_tdata      = '0;
    logic                s_tuser      = OP_PIXEL;
    logic                m_tvalid;
    logic                m_tready     = 1'b0;
    logic [31:0]         m_tdata;
    logic                m_tlast;

    binary_image_edge_extractor_core u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state: register copies, both line stores, the window and stream positions.
    logic [CFG_W-1:0] width_reg  = WIDTH_RESET;
    logic [CFG_W-1:0] height_reg = HEIGHT_RESET;
    bit               line_above [MAX_WIDTH];
    bit               line_curr  [MAX_WIDTH];
    logic [8:0]       window     = '0;
    int unsigned      pos_col    = 0;
    int unsigned      pos_row    = 0;

    edge_result_t pending_boundary[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int items_sent     = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;

    function automatic int unsigned eff_width();
        int unsigned w;
        w = 32'(width_reg);
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = 32'(height_reg);
        if (h == 0) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic logic [ALPHA_W-1:0] rand_alpha();
        if ($urandom_range(99) < 25) return '0;
        return ALPHA_W'($urandom_range(1, 255));
    endfunction

    // Advances the boundary predictor by one accepted transaction and queues its result.
    function automatic void step_boundary_model(input logic op, input logic [ALPHA_W-1:0] alpha);
        int unsigned  w, h, c, r, ocol, orow, cc;
        logic         pix, have, last, is_bnd;
        logic [2:0]   colbits;
        edge_result_t res;
        w = eff_width();
        h = eff_height();
        ocol = 0;
        orow = 0;
        cc = 1;
        have = 1'b0;
        last = 1'b0;
        if (pos_col >= w) pos_col = 0;
        if (pos_row > h + 1) begin
            pos_row = 0;
            pos_col = 0;
        end
        c = pos_col;
        r = pos_row;
        pix = (op == OP_PIXEL) && (alpha != '0);
        colbits = {pix, line_curr[c], line_above[c]};
        if (c == 0) begin
            if (r >= 2) begin
                have = 1'b1;
                orow = r - 2;
                ocol = w - 1;
                cc = 2;
            end
        end else begin
            window = {colbits, window[8:3]};
            if (r >= 1) begin
                have = 1'b1;
                orow = r - 1;
                ocol = c - 1;
                cc = 1;
            end
        end
        if (have && orow >= h) have = 1'b0;
        if (have) begin
            is_bnd = 1'b0;
            if (window[cc * 3 + 1]) begin
                for (int dc = 0; dc < 3; dc++) begin
                    for (int dr = 0; dr < 3; dr++) begin
                        if ((dc == 1 && dr == 1) || (dc == 0 && ocol == 0)
                            || (dc == 2 && ocol + 1 >= w) || (dr == 0 && orow == 0)
                            || (dr == 2 && orow + 1 >= h)) continue;
                        if (!window[(cc + dc - 1) * 3 + dr]) is_bnd = 1'b1;
                    end
                end
            end
            last = (orow == h - 1) && (ocol == w - 1);
            res.edge_value = is_bnd ? EDGE_ON : EDGE_OFF;
            res.col = ocol[OUT_POS_W-1:0];
            res.row = orow[OUT_POS_W-1:0];
            res.frame_last = last;
            pending_boundary.push_back(res);
        end
        if (c == 0) window = {colbits, window[8:3]};
        line_above[c] = line_curr[c];
        line_curr[c] = pix;
        pos_col = c + 1;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row = r + 1;
        end
        if (last) begin
            pos_col = 0;
            pos_row = 0;
        end
        pos_row = pos_row & 32'h1FFF;
    endfunction

    task automatic send_item(input logic op, input logic [ALPHA_W-1:0] alpha);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= alpha;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        step_boundary_model(op, alpha);
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_boundary.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) width_reg = val;
        else height_reg = val;
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        stop_sending();
        wait_drain();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    // One frame at the current geometry, drained by width plus one further transactions, mostly flushes.
    task automatic send_frame();
        int unsigned w, h;
        w = eff_width();
        h = eff_height();
        repeat (w * h) begin
            if ($urandom_range(99) < 4) send_item(OP_FLUSH, ALPHA_W'($urandom_range(255)));
            else send_item(OP_PIXEL, rand_alpha());
        end
        repeat (w + 1) begin
            if ($urandom_range(99) < 4) send_item(OP_PIXEL, rand_alpha());
            else send_item(OP_FLUSH, ALPHA_W'($urandom_range(255)));
        end
    endtask

    task automatic test_directed();
        logic [ALPHA_W-1:0] block3 [9];
        block3 = '{8'd0, 8'd1, 8'd255, 8'd128, 8'd2, 8'd64, 8'd255, 8'd4, 8'd8};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // A partial row at the reset geometry, then a width change restarts the column.
        send_item(OP_PIXEL, 8'd255);
        send_item(OP_PIXEL, 8'd0);
        set_geometry(13'd2, 13'd2);
        send_item(OP_PIXEL, 8'd255);
        send_item(OP_FLUSH, 8'd255);
        send_item(OP_PIXEL, 8'd1);
        send_item(OP_PIXEL, 8'd128);
        repeat (3) send_item(OP_FLUSH, 8'd0);
        set_geometry(13'd3, 13'd3);
        foreach (block3[i]) send_item(OP_PIXEL, block3[i]);
        send_item(OP_FLUSH, 8'd255);
        send_item(OP_PIXEL, 8'd255);
        send_item(OP_FLUSH, 8'd0);
        send_item(OP_FLUSH, 8'd0);
        set_geometry(13'd1, 13'd1);
        send_item(OP_PIXEL, 8'd255);
        send_item(OP_PIXEL, 8'd85);
        send_item(OP_FLUSH, 8'd170);
    endtask

    task automatic test_random_frames(input int n_items, input int idle_pct, input int stall_pct);
        int          start, pick, n;
        int unsigned c, r, w, h;
        logic [CFG_W-1:0] new_w, new_h;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = items_sent;
        while (items_sent - start < n_items) begin
            if ($urandom_range(99) < 15) begin
                n = $urandom_range(1, 20);
                repeat (n) send_item(1'($urandom_range(1)), rand_alpha());
            end
            if ($urandom_range(99) < 40) begin
                pick = $urandom_range(99);
                new_w = (pick < 5) ? '0 : (pick < 80) ? CFG_W'($urandom_range(1, 8))
                                                      : CFG_W'($urandom_range(9, 24));
                pick = $urandom_range(99);
                new_h = (pick < 5) ? '0 : (pick < 85) ? CFG_W'($urandom_range(1, 6))
                                                      : CFG_W'($urandom_range(7, 12));
                set_geometry(new_w, new_h);
            end
            forever begin
                w = eff_width();
                h = eff_height();
                c = pos_col;
                r = pos_row;
                if (c >= w) c = 0;
                if (r > h + 1) begin
                    r = 0;
                    c = 0;
                end
                if (c == 0 && r == 0) break;
                if ($urandom_range(99) < 70) send_item(OP_FLUSH, ALPHA_W'($urandom_range(255)));
                else send_item(OP_PIXEL, rand_alpha());
            end
            send_frame();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_geometry(13'd16, 13'd6);
        @(posedge aclk);
        hold_requests++;
        send_frame();
        stop_sending();
        wait_drain();
        send_frame();
    endtask

    task automatic test_extreme_sizes();
        send_idle_pct  = 0;
        recv_stall_pct = 10;
        set_geometry(13'd8191, 13'd1);
        repeat (60) send_item(OP_PIXEL, rand_alpha());
        set_geometry(13'd4096, 13'd8191);
        repeat (60) send_item(OP_PIXEL, rand_alpha());
        set_geometry(13'd0, 13'd0);
        send_frame();
    endtask

    always @(negedge aclk) begin
        if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        edge_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.edge_value = m_tdata[7:0];
            got.col        = m_tdata[19:8];
            got.row        = m_tdata[31:20];
            got.frame_last = m_tlast;
            if (pending_boundary.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result: edge %0d col %0d row %0d last %0d",
                             got.edge_value, got.col, got.row, got.frame_last);
            end else begin
                want = pending_boundary.pop_front();
                if (got.edge_value !== want.edge_value || got.col !== want.col
                    || got.row !== want.row || got.frame_last !== want.frame_last) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("result mismatch: expected edge %0d col %0d row %0d last %0d, got edge %0d col %0d row %0d last %0d",
                                 want.edge_value, want.col, want.row, want.frame_last,
                                 got.edge_value, got.col, got.row, got.frame_last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results pending",
                     quiet_cycles, pending_boundary.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_frames(200, 0, 0);
        test_random_frames(200, 69, 0);
        test_random_frames(200, 0, 69);
        test_random_frames(200, 33, 33);
        test_backpressure();
        test_extreme_sizes();
        stop_sending();
        wait_drain();
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
